FILE: design/mroe_pkg.sv
`default_nettype none
package mroe_pkg;

  localparam int unsigned MaxRowsDefault = 16;
  localparam int unsigned MaxColsDefault = 16;
  localparam int unsigned RegIdxWidth    = 1;
  localparam int unsigned CfgDataWidth   = 5;
  localparam int unsigned QueueDepth     = 2;

  localparam logic [RegIdxWidth-1:0] RegRows = 1'b0;
  localparam logic [RegIdxWidth-1:0] RegCols = 1'b1;

  typedef enum logic [2:0] {
    FuncWrite  = 3'd0,
    FuncRead   = 3'd1,
    FuncSwap   = 3'd2,
    FuncScale  = 3'd3,
    FuncDivide = 3'd4,
    FuncAdd    = 3'd5,
    FuncAddMul = 3'd6,
    FuncAddDiv = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusDivZero  = 2'd1,
    StatusOutRange = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  row_a;
    logic [3:0]  row_b;
    logic [3:0]  col;
    logic [31:0] value;
  } item_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
  } result_t;

  // Classified command handed from front to back.
  typedef struct packed {
    item_t       item;
    logic [1:0]  status;
    logic [8:0]  ncols;
  } cmd_t;

  // Saturates a 64-bit signed value to 32 bits.
  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sh7FFFFFFF) r = 32'h7FFFFFFF;
    else if (v < -64'sh80000000) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Applies a sign to a magnitude, clamping the magnitude at 2^32 first.
  function automatic logic [31:0] signed_result(input logic neg, input logic [63:0] m);
    logic [63:0] c;
    logic signed [63:0] s;
    c = (m > 64'h1_0000_0000) ? 64'h1_0000_0000 : m;
    s = neg ? -$signed(c) : $signed(c);
    return sat32(s);
  endfunction

endpackage
`default_nettype wire

FILE: design/mroe_if.sv
`default_nettype none
interface mroe_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/mroe_cfg_if.sv
`default_nettype none
interface mroe_cfg_if ();
  logic                             valid;
  logic                             ready;
  logic [mroe_pkg::RegIdxWidth-1:0] index;
  logic [31:0]                      wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

FILE: design/mroe_front.sv
`default_nettype none
module mroe_front #(
  parameter int unsigned MaxRows = mroe_pkg::MaxRowsDefault,
  parameter int unsigned MaxCols = mroe_pkg::MaxColsDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire mroe_pkg::item_t in_item_i,
  input  wire logic            cfg_valid_i,
  input  wire logic            cfg_index_i,
  input  wire logic [31:0]     cfg_wdata_i,
  output logic                 q_valid_o,
  input  wire logic            q_ready_i,
  output mroe_pkg::cmd_t       q_cmd_o
);
  localparam int unsigned Ptr = $clog2(mroe_pkg::QueueDepth);

  logic [4:0] rows_q, cols_q;
  logic [8:0] nr, nc;
  mroe_pkg::cmd_t fifo_q [mroe_pkg::QueueDepth];
  logic [Ptr-1:0] wp_q, rp_q;
  logic [Ptr:0]   cnt_q;
  mroe_pkg::cmd_t cmd;
  logic uses_b, oor, push, pop;

  always_comb begin
    nr = (9'(rows_q) > 9'(MaxRows)) ? 9'(MaxRows) : 9'(rows_q);
    nc = (9'(cols_q) > 9'(MaxCols)) ? 9'(MaxCols) : 9'(cols_q);
    uses_b = (in_item_i.func == mroe_pkg::FuncSwap) || (in_item_i.func >= mroe_pkg::FuncAdd);
    oor = (9'(in_item_i.row_a) >= nr) || (uses_b && (9'(in_item_i.row_b) >= nr)) ||
          ((in_item_i.func <= mroe_pkg::FuncRead) && (9'(in_item_i.col) >= nc));
    cmd.item  = in_item_i;
    cmd.ncols = nc;
    if (oor) cmd.status = mroe_pkg::StatusOutRange;
    else if (((in_item_i.func == mroe_pkg::FuncDivide) ||
              (in_item_i.func == mroe_pkg::FuncAddDiv)) && (in_item_i.value == 32'd0))
      cmd.status = mroe_pkg::StatusDivZero;
    else cmd.status = mroe_pkg::StatusOk;
  end

  assign in_ready_o = (cnt_q != (Ptr+1)'(mroe_pkg::QueueDepth));
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = (cnt_q != '0);
  assign pop = q_valid_o && q_ready_i;
  assign q_cmd_o = fifo_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 5'd16;
      cols_q <= 5'd16;
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == mroe_pkg::RegRows) rows_q <= cfg_wdata_i[4:0];
        else cols_q <= cfg_wdata_i[4:0];
      end
      if (push) wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (Ptr+1)'(push) - (Ptr+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= cmd;
  end
endmodule
`default_nettype wire

FILE: design/mroe_divider.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle over 48 bits.
module mroe_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [47:0] num_i,
  input  wire logic [32:0] den_i,
  output logic             done_o,
  output logic [47:0]      quo_o
);
  logic [47:0] n_q, q_q;
  logic [32:0] d_q;
  logic [33:0] r_q;
  logic [5:0]  k_q;
  logic        busy_q;
  logic [33:0] sh;

  assign sh = {r_q[32:0], n_q[47]};
  assign quo_o = q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      k_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        k_q <= 6'd48;
      end else if (busy_q) begin
        k_q <= k_q - 1'b1;
        if (k_q == 6'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= num_i;
      d_q <= den_i;
      r_q <= '0;
      q_q <= '0;
    end else if (busy_q) begin
      n_q <= {n_q[46:0], 1'b0};
      if (sh >= {1'b0, d_q}) begin
        r_q <= sh - {1'b0, d_q};
        q_q <= {q_q[46:0], 1'b1};
      end else begin
        r_q <= sh;
        q_q <= {q_q[46:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

FILE: design/mroe_back.sv
`default_nettype none
module mroe_back #(
  parameter int unsigned MaxRows = mroe_pkg::MaxRowsDefault,
  parameter int unsigned MaxCols = mroe_pkg::MaxColsDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  output logic                q_ready_o,
  input  wire mroe_pkg::cmd_t q_cmd_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output mroe_pkg::result_t   out_result_o
);
  localparam int unsigned RowW = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int unsigned ColW = (MaxCols > 1) ? $clog2(MaxCols) : 1;
  localparam int unsigned AddrW = RowW + ColW;
  localparam int unsigned Depth = 2 ** AddrW;

  typedef enum logic [3:0] {
    StIdle, StRdA, StRdB, StWaitA, StMul, StMulRnd, StDivGo, StDivWait,
    StWrA, StWrB, StResp
  } state_e;

  state_e state_q;
  mroe_pkg::cmd_t cmd_q;
  logic [31:0] mem_q [Depth];
  logic [31:0] rd_q, a_q, b_q, res_q;
  logic [AddrW-1:0] raddr, waddr;
  logic        we;
  logic [31:0] wdata;
  logic [8:0]  i_q;
  logic        phase_q;
  logic [63:0] prod_q;
  logic        neg_q;
  logic        div_start;
  logic        div_done;
  logic [47:0] div_num;
  logic [47:0] div_quo;
  logic [31:0] mul_term, div_term;
  logic [31:0] op_mag, f_mag;
  logic [RowW-1:0] ra, rb;
  logic [ColW-1:0] ci, cc;
  logic        take;

  assign ra = RowW'(cmd_q.item.row_a);
  assign rb = RowW'(cmd_q.item.row_b);
  assign cc = ColW'(cmd_q.item.col);
  assign ci = i_q[ColW-1:0];

  // One read and one write port; read data registered.
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rd_q <= mem_q[raddr];
  end

  // Adding half the divisor to the numerator rounds the magnitude to nearest,
  // with ties away from zero once the sign is applied.
  assign div_num = {op_mag, 16'h0} + 48'(f_mag[31:1]);

  mroe_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   ({1'b0, f_mag}),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // The operand is the source row's element for add-scaled and add-divided.
  always_comb begin
    logic [31:0] op;
    op = ((cmd_q.item.func == mroe_pkg::FuncAddMul) ||
          (cmd_q.item.func == mroe_pkg::FuncAddDiv)) ? b_q : a_q;
    op_mag = op[31] ? 32'(-op) : op;
    f_mag  = cmd_q.item.value[31] ? 32'(-cmd_q.item.value) : cmd_q.item.value;
  end

  assign mul_term = mroe_pkg::signed_result(neg_q, (prod_q + 64'h8000) >> 16);
  assign div_term = mroe_pkg::signed_result(neg_q, {16'h0, div_quo});

  assign take = (state_q == StIdle) && q_valid_i && !q_ready_o && !out_valid_o;

  always_comb begin
    raddr = '0;
    if (state_q == StRdB || (state_q == StRdA && phase_q)) raddr = {rb, ci};
    else if (cmd_q.item.func == mroe_pkg::FuncRead) raddr = {ra, cc};
    else raddr = {ra, ci};
    we = 1'b0;
    waddr = {ra, ci};
    wdata = res_q;
    if (state_q == StWrA) we = 1'b1;
    else if (state_q == StWrB) begin
      we = 1'b1;
      waddr = {rb, ci};
      wdata = a_q;
    end
    div_start = (state_q == StDivGo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_o <= 1'b0;
      q_ready_o <= 1'b0;
      i_q <= '0;
      phase_q <= 1'b0;
    end else begin
      q_ready_o <= take;
      case (state_q)
        StIdle: begin
          if (take) begin
            cmd_q <= q_cmd_i;
            i_q <= (q_cmd_i.item.func == mroe_pkg::FuncWrite) ? 9'(q_cmd_i.item.col) : 9'd0;
            phase_q <= 1'b0;
            out_result_o <= '{read_value: 32'd0, status: q_cmd_i.status};
            if (q_cmd_i.status != mroe_pkg::StatusOk) state_q <= StResp;
            else if (q_cmd_i.item.func == mroe_pkg::FuncWrite) begin
              res_q <= q_cmd_i.item.value;
              state_q <= StWrA;
            end else if (q_cmd_i.item.func == mroe_pkg::FuncRead) state_q <= StRdA;
            else if (q_cmd_i.ncols == 9'd0) state_q <= StResp;
            else state_q <= StRdA;
          end
        end
        StRdA: begin
          // Address for A is presented now; B next.
          if (cmd_q.item.func == mroe_pkg::FuncRead) state_q <= StWaitA;
          else state_q <= StRdB;
        end
        StRdB: begin
          a_q <= rd_q;
          state_q <= StWaitA;
        end
        StWaitA: begin
          if (cmd_q.item.func == mroe_pkg::FuncRead) begin
            out_result_o.read_value <= rd_q;
            state_q <= StResp;
          end else begin
            b_q <= rd_q;
            case (cmd_q.item.func)
              mroe_pkg::FuncSwap: begin
                res_q <= rd_q;
                state_q <= StWrA;
              end
              mroe_pkg::FuncAdd: begin
                res_q <= mroe_pkg::sat32(64'($signed(a_q)) + 64'($signed(rd_q)));
                state_q <= StWrA;
              end
              mroe_pkg::FuncScale, mroe_pkg::FuncAddMul: state_q <= StMul;
              default: state_q <= StDivGo;
            endcase
          end
        end
        StMul: begin
          prod_q <= 64'(op_mag) * 64'(f_mag);
          neg_q <= (cmd_q.item.func == mroe_pkg::FuncAddMul ? b_q[31] : a_q[31]) ^
                   cmd_q.item.value[31];
          state_q <= StMulRnd;
        end
        StMulRnd: begin
          if (cmd_q.item.func == mroe_pkg::FuncAddMul)
            res_q <= mroe_pkg::sat32(64'($signed(a_q)) + 64'($signed(mul_term)));
          else res_q <= mul_term;
          state_q <= StWrA;
        end
        StDivGo: begin
          neg_q <= (cmd_q.item.func == mroe_pkg::FuncAddDiv ? b_q[31] : a_q[31]) ^
                   cmd_q.item.value[31];
          state_q <= StDivWait;
        end
        StDivWait: begin
          if (div_done) begin
            res_q <= (cmd_q.item.func == mroe_pkg::FuncAddDiv) ?
                     mroe_pkg::sat32(64'($signed(a_q)) + 64'($signed(div_term))) : div_term;
            state_q <= StWrA;
          end
        end
        StWrA: begin
          if (cmd_q.item.func == mroe_pkg::FuncWrite) state_q <= StResp;
          else if (cmd_q.item.func == mroe_pkg::FuncSwap) state_q <= StWrB;
          else if (i_q + 9'd1 >= cmd_q.ncols) state_q <= StResp;
          else begin
            i_q <= i_q + 9'd1;
            state_q <= StRdA;
          end
        end
        StWrB: begin
          if (i_q + 9'd1 >= cmd_q.ncols) state_q <= StResp;
          else begin
            i_q <= i_q + 9'd1;
            state_q <= StRdA;
          end
        end
        StResp: begin
          out_valid_o <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
    end
  end
endmodule
`default_nettype wire

FILE: design/matrix_row_operation_engine_core.sv
// Channel | Direction | Payload
// in_ch   | sink      | func, row_a, row_b, col, value
// out_ch  | source    | read_value, status
// cfg_ch  | sink      | index (0 rows_in_use, 1 cols_in_use), wdata
// Element writes and reads touch one element; a row operation walks the columns in
// use; swap writes both rows, and the scaled and divided forms pass each element
// through the multiplier or the 48-bit bit-serial divider. A two-entry queue
// decouples the front; the input stalls only when that queue is full.
// Reset is asynchronous and clears control state; the matrix store is not cleared.
`default_nettype none
module matrix_row_operation_engine_core #(
  parameter int unsigned MaxRows = mroe_pkg::MaxRowsDefault,
  parameter int unsigned MaxCols = mroe_pkg::MaxColsDefault
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  mroe_if.sink     in_ch,
  mroe_if.source   out_ch,
  mroe_cfg_if.sink cfg_ch
);
  logic qv, qr;
  mroe_pkg::cmd_t qc;

  assign cfg_ch.ready = 1'b1;

  mroe_front #(.MaxRows(MaxRows), .MaxCols(MaxCols)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i (in_ch.valid), .in_ready_o (in_ch.ready), .in_item_i (in_ch.data),
    .cfg_valid_i (cfg_ch.valid), .cfg_index_i (cfg_ch.index), .cfg_wdata_i (cfg_ch.wdata),
    .q_valid_o (qv), .q_ready_i (qr), .q_cmd_o (qc)
  );

  mroe_back #(.MaxRows(MaxRows), .MaxCols(MaxCols)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i (qv), .q_ready_o (qr), .q_cmd_i (qc),
    .out_valid_o (out_ch.valid), .out_ready_i (out_ch.ready), .out_result_o (out_ch.data)
  );
endmodule
`default_nettype wire

FILE: design/mroe_checker.sv
`default_nettype none
module mroe_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [33:0] out_data
);
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data[1:0] != 2'd3)
    else $error("bad status");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data[1:0] != 2'd0 |-> out_data[33:2] == 32'd0)
    else $error("nonzero read on error");
endmodule
bind matrix_row_operation_engine_core mroe_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .out_data(out_ch.data));
`default_nettype wire

FILE: tb/sv/matrix_row_operation_engine_core_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module matrix_row_operation_engine_core_tb;

  localparam int unsigned NRows     = 16;
  localparam int unsigned NCols     = 16;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned PhaseLen  = 87;

  typedef struct {
    bit                is_cfg;
    logic              idx;
    logic [31:0]       wdata;
    mroe_pkg::item_t   it;
    bit                has_exp;
    mroe_pkg::result_t exp_res;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  mroe_if #(.T(mroe_pkg::item_t))   in_ch ();
  mroe_if #(.T(mroe_pkg::result_t)) out_ch ();
  mroe_cfg_if                       cfg_ch ();

  matrix_row_operation_engine_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow of the matrix and the two size registers.
  logic signed [31:0] shadow_mat [NRows][NCols];
  logic [4:0]         rows_reg;
  logic [4:0]         cols_reg;

  mroe_pkg::result_t pending_results [$];
  mroe_pkg::result_t typed_results [$];
  bit                typed_valid [$];
  stim_row_t         directed_rows [$];

  int unsigned mismatches;
  int unsigned accepted_items;
  int unsigned idle_cycles;
  bit          hold_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] magnitude(logic signed [31:0] v);
    logic signed [63:0] e;
    e = v;
    return (e < 0) ? -e : e;
  endfunction

  function automatic logic signed [31:0] clamp_sign(logic neg, logic [63:0] m);
    logic signed [63:0] s;
    if (m > 64'h1_0000_0000) m = 64'h1_0000_0000;
    s = neg ? -$signed(m) : $signed(m);
    if (s > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (s < -64'sh8000_0000) return 32'h8000_0000;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] fx_mul(logic signed [31:0] a, logic signed [31:0] f);
    logic [63:0] m;
    m = (magnitude(a) * magnitude(f) + 64'h8000) >> 16;
    return clamp_sign(a[31] != f[31], m);
  endfunction

  function automatic logic signed [31:0] fx_div(logic signed [31:0] a, logic signed [31:0] d);
    logic [63:0] nd;
    logic [63:0] q;
    nd = magnitude(d);
    q = ((magnitude(a) << 16) + nd / 2) / nd;
    return clamp_sign(a[31] != d[31], q);
  endfunction

  function automatic logic signed [31:0] fx_add(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s > 33'sh0_7FFF_FFFF) return 32'h7FFF_FFFF;
    if (s < -33'sh0_8000_0000) return 32'h8000_0000;
    return s[31:0];
  endfunction

  function automatic int unsigned live_rows();
    return (rows_reg > NRows) ? NRows : rows_reg;
  endfunction

  function automatic int unsigned live_cols();
    return (cols_reg > NCols) ? NCols : cols_reg;
  endfunction

  // Applies one row operation to the shadow matrix and returns its result.
  function automatic mroe_pkg::result_t apply_row_op(mroe_pkg::item_t it);
    mroe_pkg::result_t  res;
    mroe_pkg::func_e    f;
    int unsigned        nr;
    int unsigned        nc;
    bit                 uses_b;
    logic signed [31:0] v;
    logic signed [31:0] src [NCols];
    res.read_value = '0;
    res.status = mroe_pkg::StatusOk;
    f = mroe_pkg::func_e'(it.func);
    nr = live_rows();
    nc = live_cols();
    v = it.value;
    uses_b = (f == mroe_pkg::FuncSwap) || (f == mroe_pkg::FuncAdd) ||
             (f == mroe_pkg::FuncAddMul) || (f == mroe_pkg::FuncAddDiv);
    if (it.row_a >= nr || (uses_b && it.row_b >= nr) ||
        ((f == mroe_pkg::FuncWrite || f == mroe_pkg::FuncRead) && it.col >= nc)) begin
      res.status = mroe_pkg::StatusOutRange;
    end else if ((f == mroe_pkg::FuncDivide || f == mroe_pkg::FuncAddDiv) && v == 0) begin
      res.status = mroe_pkg::StatusDivZero;
    end else begin
      for (int i = 0; i < NCols; i++) src[i] = shadow_mat[it.row_b][i];
      case (f)
        mroe_pkg::FuncWrite: shadow_mat[it.row_a][it.col] = v;
        mroe_pkg::FuncRead:  res.read_value = shadow_mat[it.row_a][it.col];
        default: begin
          for (int i = 0; i < nc; i++) begin
            case (f)
              mroe_pkg::FuncSwap: begin
                shadow_mat[it.row_b][i] = shadow_mat[it.row_a][i];
                shadow_mat[it.row_a][i] = src[i];
              end
              mroe_pkg::FuncScale:
                shadow_mat[it.row_a][i] = fx_mul(shadow_mat[it.row_a][i], v);
              mroe_pkg::FuncDivide:
                shadow_mat[it.row_a][i] = fx_div(shadow_mat[it.row_a][i], v);
              mroe_pkg::FuncAdd:
                shadow_mat[it.row_a][i] = fx_add(shadow_mat[it.row_a][i], src[i]);
              mroe_pkg::FuncAddMul:
                shadow_mat[it.row_a][i] = fx_add(shadow_mat[it.row_a][i], fx_mul(src[i], v));
              default:
                shadow_mat[it.row_a][i] = fx_add(shadow_mat[it.row_a][i], fx_div(src[i], v));
            endcase
          end
        end
      endcase
    end
    return res;
  endfunction

  function automatic mroe_pkg::item_t make_item(mroe_pkg::func_e f, int ra, int rb, int c,
                                                logic [31:0] v);
    mroe_pkg::item_t it;
    it.func = f;
    it.row_a = 4'(ra);
    it.row_b = 4'(rb);
    it.col = 4'(c);
    it.value = v;
    return it;
  endfunction

  function automatic logic [31:0] rand_value(bit divisor);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 30) return $urandom;
    if (sel < 75) return {{16{1'b0}}, 16'($urandom)} + (($urandom_range(0, 8) - 4) << 16);
    if (sel < 85) return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    if (sel < 92 || !divisor) return $urandom_range(0, 3) - 1;
    return 32'h0;
  endfunction

  function automatic mroe_pkg::item_t rand_item();
    int unsigned     w;
    int unsigned     nr;
    int unsigned     nc;
    mroe_pkg::func_e f;
    mroe_pkg::item_t it;
    w = $urandom_range(0, 99);
    if (w < 25) f = mroe_pkg::FuncWrite;
    else if (w < 45) f = mroe_pkg::FuncRead;
    else if (w < 55) f = mroe_pkg::FuncSwap;
    else if (w < 65) f = mroe_pkg::FuncScale;
    else if (w < 70) f = mroe_pkg::FuncDivide;
    else if (w < 82) f = mroe_pkg::FuncAdd;
    else if (w < 94) f = mroe_pkg::FuncAddMul;
    else f = mroe_pkg::FuncAddDiv;
    nr = live_rows();
    nc = live_cols();
    it = make_item(f, $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                   rand_value(f == mroe_pkg::FuncDivide || f == mroe_pkg::FuncAddDiv));
    if (nr > 0 && $urandom_range(0, 9) < 8) begin
      it.row_a = 4'($urandom_range(0, nr - 1));
      it.row_b = 4'($urandom_range(0, nr - 1));
    end
    if (nc > 0 && $urandom_range(0, 9) < 8) it.col = 4'($urandom_range(0, nc - 1));
    return it;
  endfunction

  // Stretches without idling on either side.
  function automatic int unsigned draw_gap();
    if ((accepted_items / 100) % 4 == 3) return 0;
    return $urandom_range(0, 4);
  endfunction

  task automatic send_item(mroe_pkg::item_t it, bit has_exp, mroe_pkg::result_t exp_res);
    int unsigned gap;
    gap = draw_gap();
    typed_valid.push_back(has_exp);
    typed_results.push_back(exp_res);
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic write_reg(logic idx, logic [31:0] wdata);
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0 || typed_valid.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= wdata;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic add_op(mroe_pkg::func_e f, int ra, int rb, int c, logic [31:0] v);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.it = make_item(f, ra, rb, c, v);
    r.has_exp = 1'b0;
    directed_rows.push_back(r);
  endtask

  task automatic add_checked(mroe_pkg::func_e f, int ra, int rb, int c, logic [31:0] v,
                             logic [31:0] rv, mroe_pkg::status_e st);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.it = make_item(f, ra, rb, c, v);
    r.has_exp = 1'b1;
    r.exp_res.read_value = rv;
    r.exp_res.status = st;
    directed_rows.push_back(r);
  endtask

  task automatic add_cfg(logic idx, logic [31:0] wdata);
    stim_row_t r;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.wdata = wdata;
    directed_rows.push_back(r);
  endtask

  // Prediction and checking at the rising edge.
  always @(posedge clk_i) begin
    mroe_pkg::result_t exp_res;
    mroe_pkg::result_t pred;
    bit                typed;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: actual value %h status %0d", $time,
                   out_ch.data.read_value, out_ch.data.status);
          mismatches++;
        end else begin
          exp_res = pending_results.pop_front();
          if (out_ch.data.read_value !== exp_res.read_value) begin
            $display("%0t: read_value mismatch: expected %h actual %h", $time,
                     exp_res.read_value, out_ch.data.read_value);
            mismatches++;
          end
          if (out_ch.data.status !== exp_res.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d", $time,
                     exp_res.status, out_ch.data.status);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pred = apply_row_op(in_ch.data);
        typed = typed_valid.pop_front();
        exp_res = typed_results.pop_front();
        pending_results.push_back(typed ? exp_res : pred);
        accepted_items++;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == mroe_pkg::RegRows) rows_reg = cfg_ch.wdata[4:0];
        else cols_reg = cfg_ch.wdata[4:0];
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus one long hold so the block backs up.
  initial begin
    int unsigned gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap();
      if (!hold_done && accepted_items >= 400) begin
        hold_done = 1'b1;
        gap = 400;
      end
      @(negedge clk_i);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  initial begin
    logic [4:0]        phase_cfg [7][2];
    mroe_pkg::result_t none;
    mismatches = 0;
    accepted_items = 0;
    idle_cycles = 0;
    hold_done = 1'b0;
    rows_reg = 5'd16;
    cols_reg = 5'd16;
    none = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = mroe_pkg::RegRows;
    cfg_ch.wdata = '0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The store is not cleared by reset, so every element is loaded first.
    for (int r = 0; r < NRows; r++) begin
      for (int c = 0; c < NCols; c++) begin
        send_item(make_item(mroe_pkg::FuncWrite, r, 0, c, rand_value(1'b0)), 1'b0, none);
      end
    end

    add_op(mroe_pkg::FuncWrite, 0, 0, 0, 32'h7FFF_FFFF);
    add_checked(mroe_pkg::FuncRead, 0, 0, 0, 0, 32'h7FFF_FFFF, mroe_pkg::StatusOk);
    add_op(mroe_pkg::FuncWrite, 0, 0, 1, 32'h8000_0000);
    add_checked(mroe_pkg::FuncRead, 0, 0, 1, 0, 32'h8000_0000, mroe_pkg::StatusOk);
    add_op(mroe_pkg::FuncScale, 0, 0, 0, 32'h7FFF_FFFF);
    add_checked(mroe_pkg::FuncDivide, 1, 0, 0, 32'h0, 32'h0, mroe_pkg::StatusDivZero);
    add_checked(mroe_pkg::FuncAddDiv, 2, 3, 0, 32'h0, 32'h0, mroe_pkg::StatusDivZero);
    add_op(mroe_pkg::FuncDivide, 2, 0, 0, 32'h1);
    add_op(mroe_pkg::FuncScale, 3, 0, 0, 32'h8000_0000);
    add_op(mroe_pkg::FuncSwap, 4, 4, 0, 32'h0);
    add_op(mroe_pkg::FuncSwap, 5, 6, 0, 32'h0);
    add_op(mroe_pkg::FuncAdd, 7, 7, 0, 32'h0);
    add_op(mroe_pkg::FuncAddMul, 8, 8, 0, 32'h0001_8000);
    add_op(mroe_pkg::FuncAddMul, 9, 10, 0, 32'h8000_0000);
    add_op(mroe_pkg::FuncAddDiv, 11, 11, 0, 32'hFFFF_0000);
    add_op(mroe_pkg::FuncAddDiv, 12, 13, 0, 32'h1);
    add_op(mroe_pkg::FuncAdd, 14, 15, 0, 32'h0);
    add_cfg(mroe_pkg::RegRows, 32'd4);
    add_cfg(mroe_pkg::RegCols, 32'hFFFF_FFE2);
    add_op(mroe_pkg::FuncRead, 3, 0, 1, 0);
    add_checked(mroe_pkg::FuncRead, 5, 0, 0, 0, 32'h0, mroe_pkg::StatusOutRange);
    add_checked(mroe_pkg::FuncRead, 0, 0, 2, 0, 32'h0, mroe_pkg::StatusOutRange);
    add_checked(mroe_pkg::FuncSwap, 0, 9, 0, 0, 32'h0, mroe_pkg::StatusOutRange);
    // The range check wins over the zero divisor.
    add_checked(mroe_pkg::FuncDivide, 9, 0, 0, 32'h0, 32'h0, mroe_pkg::StatusOutRange);
    add_checked(mroe_pkg::FuncWrite, 15, 0, 15, 32'h1, 32'h0, mroe_pkg::StatusOutRange);
    add_cfg(mroe_pkg::RegRows, 32'd0);
    add_checked(mroe_pkg::FuncRead, 0, 0, 0, 0, 32'h0, mroe_pkg::StatusOutRange);
    add_checked(mroe_pkg::FuncAdd, 0, 0, 0, 0, 32'h0, mroe_pkg::StatusOutRange);
    add_cfg(mroe_pkg::RegRows, 32'd31);
    add_cfg(mroe_pkg::RegCols, 32'd0);
    add_checked(mroe_pkg::FuncRead, 0, 0, 0, 0, 32'h0, mroe_pkg::StatusOutRange);
    add_checked(mroe_pkg::FuncScale, 0, 0, 0, 32'h0002_0000, 32'h0, mroe_pkg::StatusOk);
    add_checked(mroe_pkg::FuncSwap, 1, 15, 0, 0, 32'h0, mroe_pkg::StatusOk);
    add_cfg(mroe_pkg::RegCols, 32'd31);
    add_op(mroe_pkg::FuncRead, 15, 0, 15, 0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) write_reg(directed_rows[i].idx, directed_rows[i].wdata);
      else send_item(directed_rows[i].it, directed_rows[i].has_exp, directed_rows[i].exp_res);
    end

    phase_cfg = '{'{5'd16, 5'd16}, '{5'd8, 5'd5}, '{5'd31, 5'd20}, '{5'd1, 5'd1},
                  '{5'd16, 5'd3}, '{5'd3, 5'd16}, '{5'd16, 5'd16}};
    foreach (phase_cfg[p]) begin
      write_reg(mroe_pkg::RegRows, {$urandom} << 5 | phase_cfg[p][0]);
      write_reg(mroe_pkg::RegCols, {$urandom} << 5 | phase_cfg[p][1]);
      for (int n = 0; n < PhaseLen; n++) send_item(rand_item(), 1'b0, none);
    end

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0 || typed_valid.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
